### hw/rtl/pcm_pkg.sv
// Package for the packed counting multiset: opcodes, status codes, controller states,
// field widths and the structs passed between the controller, the counter store and the top.
// No dependencies.
package pcm_pkg;

   localparam int ID_W     = 10;   // width of an ID and of the highest_id register
   localparam int TOTAL_W  = 18;   // width of the instance total and of a rank
   localparam int CNT_W    = 8;    // width of the count in a result word
   localparam int FUNC_W   = 3;
   localparam int REQ_W    = 32;   // id and rank packed, padded to whole bytes
   localparam int RSP_W    = 40;   // result fields packed, padded to whole bytes

   localparam logic [ID_W-1:0] HIGHEST_RESET = 10'd127;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT    = 3'd0,
      FN_ERASE     = 3'd1,
      FN_ERASE_ALL = 3'd2,
      FN_QUERY     = 3'd3,
      FN_FIND_MAX  = 3'd4,
      FN_POP_MAX   = 3'd5,
      FN_SELECT    = 3'd6,
      FN_CLEAR     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_NONE  = 2'd1,
      STAT_RANGE = 2'd2
   } stat_type;

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_MOD,
      S_SCAN,
      S_HOLD
   } state_type;

   // Request from the controller to the counter store. Addresses and data are
   // carried at their largest widths; the store uses the low bits it needs.
   typedef struct packed {
      logic            wr_en;
      logic [ID_W-1:0] wr_addr;
      logic [CNT_W-1:0] wr_data;
      logic            rd_en;
      logic [ID_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [ID_W-1:0]    found_id;
      logic [CNT_W-1:0]   count_value;
      logic               present;
      stat_type           status;
   } result_type;

endpackage

### hw/rtl/pcm_store.sv
// Counter store of the packed counting multiset: one synchronous memory with one write
// port and one registered read port. Depends on pcm_pkg.
module pcm_store import pcm_pkg::*; #(
   parameter int ENTRIES    = 128,
   parameter int COUNT_BITS = 1
) (
   input  logic                  clock,
   input  mem_req_type           mem,
   output logic [COUNT_BITS-1:0] rd_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [COUNT_BITS-1:0] store_mem [ENTRIES];
   logic [COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         store_mem[mem.wr_addr[IDX_W-1:0]] <= mem.wr_data[COUNT_BITS-1:0];
      end
      if (mem.rd_en) begin
         rd_data_ff <= store_mem[mem.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pcm_ctrl.sv
// Sequencer of the packed counting multiset: clearing pass, point read-modify-write,
// downward and upward scans, and the instance total. Depends on pcm_pkg.
module pcm_ctrl import pcm_pkg::*; #(
   parameter int ENTRIES    = 128,
   parameter int COUNT_BITS = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  func_type              req_func,
   input  logic [ID_W-1:0]       req_id,
   input  logic [TOTAL_W-1:0]    req_rank,
   input  logic                  wipe,
   input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] top_id,
   input  logic                  out_free,
   output logic                  res_valid,
   output result_type            res,
   output mem_req_type           mem,
   input  logic [COUNT_BITS-1:0] rd_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [TOTAL_W-1:0] rank_ff, rank_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               clr_res_ff, clr_res_in;
   result_type         hold_ff, hold_in;

   logic               res_make;
   result_type         res_d;
   logic [TOTAL_W:0]   acc_sum;
   logic [ID_W-1:0]    top_ext;

   assign top_ext = ID_W'(top_id);
   assign acc_sum = {1'b0, acc_ff} + (TOTAL_W + 1)'(rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         total_ff   <= '0;
         clr_ff     <= '0;
         clr_res_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         clr_ff     <= clr_in;
         clr_res_ff <= clr_res_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      rank_ff <= rank_in;
      acc_ff  <= acc_in;
      cur_ff  <= cur_in;
      hold_ff <= hold_in;
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      rank_in    = rank_ff;
      total_in   = total_ff;
      acc_in     = acc_ff;
      cur_in     = cur_ff;
      clr_in     = clr_ff;
      clr_res_in = clr_res_ff;
      hold_in    = hold_ff;
      req_ready  = 1'b0;
      mem        = '0;
      res_make   = 1'b0;
      res_d      = '0;

      unique case (state_ff)
         S_CLR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = ID_W'(clr_ff);
            if (clr_ff == LAST_IDX) begin
               if (clr_res_ff) begin
                  res_make = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            // A register write in this cycle takes priority over a new word.
            req_ready = !wipe;
            if (req_valid && !wipe) begin
               func_in = req_func;
               rank_in = req_rank;
               unique case (req_func) inside
                  FN_INSERT, FN_ERASE, FN_ERASE_ALL, FN_QUERY: begin
                     if (req_id > top_ext) begin
                        res_make     = 1'b1;
                        res_d.status = STAT_RANGE;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = req_id;
                        cur_in      = req_id[IDX_W-1:0];
                        state_in    = S_MOD;
                     end
                  end
                  FN_FIND_MAX, FN_POP_MAX: begin
                     if (total_ff == '0) begin
                        res_make     = 1'b1;
                        res_d.status = STAT_RANGE;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = top_ext;
                        cur_in      = top_id;
                        state_in    = S_SCAN;
                     end
                  end
                  FN_SELECT: begin
                     if (req_rank >= total_ff) begin
                        res_make     = 1'b1;
                        res_d.status = STAT_RANGE;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = '0;
                        cur_in      = '0;
                        acc_in      = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     total_in   = '0;
                     clr_in     = '0;
                     clr_res_in = 1'b1;
                     state_in   = S_CLR;
                  end
               endcase
            end
         end

         S_MOD: begin
            // The read issued at acceptance has landed; modify and write back.
            res_make            = 1'b1;
            res_d.present       = (rd_data != '0);
            res_d.count_value   = CNT_W'(rd_data);
            mem.wr_addr         = ID_W'(cur_ff);
            case (func_ff)
               FN_INSERT: begin
                  if (rd_data == CNT_FULL) begin
                     res_d.status = STAT_NONE;
                  end else begin
                     mem.wr_en         = 1'b1;
                     mem.wr_data       = CNT_W'(rd_data + 1'b1);
                     res_d.count_value = CNT_W'(rd_data + 1'b1);
                     total_in          = total_ff + 1'b1;
                  end
               end
               FN_ERASE: begin
                  if (rd_data == '0) begin
                     res_d.status = STAT_NONE;
                  end else begin
                     mem.wr_en         = 1'b1;
                     mem.wr_data       = CNT_W'(rd_data - 1'b1);
                     res_d.count_value = CNT_W'(rd_data - 1'b1);
                     total_in          = total_ff - 1'b1;
                  end
               end
               FN_ERASE_ALL: begin
                  if (rd_data == '0) begin
                     res_d.status = STAT_NONE;
                  end else begin
                     mem.wr_en         = 1'b1;
                     mem.wr_data       = '0;
                     res_d.count_value = '0;
                     total_in          = total_ff - TOTAL_W'(rd_data);
                  end
               end
               default: begin
               end
            endcase
         end

         S_SCAN: begin
            // One entry per cycle: check the word that landed and read the next one.
            if (func_ff == FN_SELECT) begin
               if (rd_data != '0 && acc_sum > {1'b0, rank_ff}) begin
                  res_make          = 1'b1;
                  res_d.present     = 1'b1;
                  res_d.count_value = CNT_W'(rd_data);
                  res_d.found_id    = ID_W'(cur_ff);
               end else if (cur_ff == top_id) begin
                  res_make     = 1'b1;
                  res_d.status = STAT_RANGE;
               end else begin
                  acc_in      = acc_sum[TOTAL_W-1:0];
                  cur_in      = cur_ff + 1'b1;
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = ID_W'(cur_ff + 1'b1);
               end
            end else begin
               if (rd_data != '0) begin
                  res_make          = 1'b1;
                  res_d.present     = 1'b1;
                  res_d.found_id    = ID_W'(cur_ff);
                  res_d.count_value = CNT_W'(rd_data);
                  if (func_ff == FN_POP_MAX) begin
                     mem.wr_en         = 1'b1;
                     mem.wr_addr       = ID_W'(cur_ff);
                     mem.wr_data       = CNT_W'(rd_data - 1'b1);
                     res_d.count_value = CNT_W'(rd_data - 1'b1);
                     total_in          = total_ff - 1'b1;
                  end
               end else if (cur_ff == '0) begin
                  res_make     = 1'b1;
                  res_d.status = STAT_RANGE;
               end else begin
                  cur_in      = cur_ff - 1'b1;
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = ID_W'(cur_ff - 1'b1);
               end
            end
         end

         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      res_d.total = total_in;

      if (res_make) begin
         hold_in  = res_d;
         state_in = out_free ? S_IDLE : S_HOLD;
      end

      // A register write wipes the store and the total.
      if (wipe) begin
         total_in   = '0;
         clr_in     = '0;
         clr_res_in = 1'b0;
         state_in   = S_CLR;
      end
   end

   assign res_valid = res_make || (state_ff == S_HOLD);
   assign res       = (state_ff == S_HOLD) ? hold_ff : res_d;

   a_mod_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> $past(req_valid && req_ready))
      else $error("write-back state entered without an accepted word");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cur_ff <= top_id))
      else $error("scan pointer beyond the highest ID");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      mem.wr_en |-> (mem.wr_addr <= ID_W'(ENTRIES - 1)))
      else $error("store write beyond the last entry");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_HOLD) |-> $past(!out_free))
      else $error("result parked although the output register was free");

endmodule

### hw/rtl/packed_counting_multiset.sv
// Top level of the packed counting multiset: stream ports, highest_id register,
// output register, and the controller and counter store. Depends on pcm_pkg,
// pcm_store and pcm_ctrl.
//
//   channel  ports                               direction  word
//   req      req_tvalid/tready/tdata/tuser      in         one operation
//   rsp      rsp_tvalid/tready/tdata            out        one result per operation
//   csr      csr_valid/csr_ready/csr_wdata      in         highest_id write
//
// Insert, erase, erase all and query read the counter from the store in the cycle of
// acceptance; a change is written back in the next one. An ID out of
// range is answered in the cycle of acceptance.
// Find max and pop max walk down from the highest ID one store word per cycle, and
// select nth walks up from ID 0 the same way.
// Clear, reset and any highest_id write run a clearing pass over every entry of the
// store; no word is accepted meanwhile (register writes still are, and restart it).
// The result sits in an output register, so the next word is accepted while a result
// waits; a result that finds the register still full is parked in the controller.
module packed_counting_multiset import pcm_pkg::*; #(
   parameter int ENTRIES    = 128,
   parameter int COUNT_BITS = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // id [9:0], rank [27:10], zero [31:28]
   input  logic [FUNC_W-1:0] req_tuser,  // func [2:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // status [1:0], present [2], count_value [10:3],
                                         // found_id [20:11], total [38:21], zero [39]
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [ID_W-1:0]  csr_wdata    // highest_id [9:0]
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [ID_W:0] ENTRIES_EXT = (ID_W + 1)'(ENTRIES);

   logic [ID_W-1:0] highest_ff, highest_in;
   logic [IDX_W-1:0] top_id;
   logic            wipe;

   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff, out_data_in;
   logic            out_free;

   logic            res_valid;
   result_type      res;
   mem_req_type     mem;
   logic [COUNT_BITS-1:0] rd_data;

   // The register is always writable; every write wipes the store.
   assign csr_ready  = 1'b1;
   assign wipe       = csr_valid;
   assign highest_in = csr_valid ? csr_wdata : highest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff <= HIGHEST_RESET;
      end else begin
         highest_ff <= highest_in;
      end
   end

   // A highest_id at or above the entry count means the last entry.
   assign top_id = ({1'b0, highest_ff} >= ENTRIES_EXT) ? IDX_W'(ENTRIES - 1)
                                                        : highest_ff[IDX_W-1:0];

   pcm_ctrl #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (func_type'(req_tuser)),
      .req_id    (req_tdata[ID_W-1:0]),
      .req_rank  (req_tdata[ID_W+TOTAL_W-1:ID_W]),
      .wipe      (wipe),
      .top_id    (top_id),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .mem       (mem),
      .rd_data   (rd_data)
   );

   pcm_store #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock   (clock),
      .mem     (mem),
      .rd_data (rd_data)
   );

   // Output register: loads when empty or when its word leaves in the same cycle.
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (res_valid && out_free) begin
         out_valid_in = 1'b1;
         out_data_in  = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule

### verif/tb_packed_counting_multiset.sv
// Self-checking testbench for packed_counting_multiset: directed and random operations
// against a shadow multiset, with random idling on both streams. Depends on pcm_pkg
// and the packed_counting_multiset RTL.
module tb_packed_counting_multiset;
   import pcm_pkg::*;

   localparam int ENTRIES    = 128;
   localparam int COUNT_BITS = 1;
   localparam logic [CNT_W-1:0]   COUNT_FULL = CNT_W'((1 << COUNT_BITS) - 1);
   localparam logic [ID_W-1:0]    TOP_LIMIT  = ID_W'(ENTRIES - 1);
   localparam logic [ID_W-1:0]    ID_MAX     = '1;
   localparam logic [TOTAL_W-1:0] RANK_MAX   = 18'd261119;
   localparam int RANDOM_PER_SETTING = 125;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0] req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [ID_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the multiset and of the highest_id register.
   logic [CNT_W-1:0]   shadow_count [ENTRIES];
   logic [TOTAL_W-1:0] shadow_total;
   logic [ID_W-1:0]    shadow_highest;

   result_type pending_results [$];
   logic       gaps_on = 1'b1;
   int         fail_count = 0;
   int         ops_sent = 0;
   int         results_checked = 0;
   int         settings_used = 1;
   int         ready_hold = 0;

   packed_counting_multiset #(
      .ENTRIES   (ENTRIES),
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void wipe_shadow();
      for (int i = 0; i < ENTRIES; i++) shadow_count[i] = '0;
      shadow_total = '0;
   endfunction

   // Register values at or above the entry count saturate to the last entry.
   function automatic logic [ID_W-1:0] effective_top();
      return (shadow_highest > TOP_LIMIT) ? TOP_LIMIT : shadow_highest;
   endfunction

   // Applies one operation to the shadow multiset and returns the result word it gives.
   function automatic result_type apply_op(func_type f, logic [ID_W-1:0] id,
                                           logic [TOTAL_W-1:0] rank);
      result_type         r;
      logic [ID_W-1:0]    top;
      logic [CNT_W-1:0]   c;
      logic [TOTAL_W-1:0] acc;
      logic               hit;
      r = '0;
      r.status = STAT_DONE;
      top = effective_top();
      hit = 1'b0;
      acc = '0;
      case (f)
         FN_INSERT, FN_ERASE, FN_ERASE_ALL, FN_QUERY: begin
            if (id > top) begin
               r.status = STAT_RANGE;
            end else begin
               c = shadow_count[id];
               r.present = (c != '0);
               if (f == FN_INSERT) begin
                  if (c >= COUNT_FULL) begin
                     r.status = STAT_NONE;
                  end else begin
                     c = c + 8'd1;
                     shadow_total = shadow_total + 18'd1;
                  end
               end else if (f == FN_ERASE) begin
                  if (c == '0) begin
                     r.status = STAT_NONE;
                  end else begin
                     c = c - 8'd1;
                     shadow_total = shadow_total - 18'd1;
                  end
               end else if (f == FN_ERASE_ALL) begin
                  if (c == '0) begin
                     r.status = STAT_NONE;
                  end else begin
                     shadow_total = shadow_total - TOTAL_W'(c);
                     c = '0;
                  end
               end
               shadow_count[id] = c;
               r.count_value = c;
            end
         end
         FN_FIND_MAX, FN_POP_MAX: begin
            r.status = STAT_RANGE;
            if (shadow_total != '0) begin
               for (int i = int'(top); i >= 0 && !hit; i--) begin
                  if (shadow_count[i] != '0) begin
                     hit = 1'b1;
                     r.status = STAT_DONE;
                     r.present = 1'b1;
                     r.found_id = ID_W'(i);
                     c = shadow_count[i];
                     if (f == FN_POP_MAX) begin
                        c = c - 8'd1;
                        shadow_count[i] = c;
                        shadow_total = shadow_total - 18'd1;
                     end
                     r.count_value = c;
                  end
               end
            end
         end
         FN_SELECT: begin
            r.status = STAT_RANGE;
            if (rank < shadow_total) begin
               for (int i = 0; i <= int'(top) && !hit; i++) begin
                  c = shadow_count[i];
                  if (c != '0) begin
                     if (acc + TOTAL_W'(c) > rank) begin
                        hit = 1'b1;
                        r.status = STAT_DONE;
                        r.present = 1'b1;
                        r.found_id = ID_W'(i);
                        r.count_value = c;
                     end
                     acc = acc + TOTAL_W'(c);
                  end
               end
            end
         end
         default: begin
            wipe_shadow();
         end
      endcase
      r.total = shadow_total;
      return r;
   endfunction

   // Sends one operation word, optionally after an idle burst, and records the result
   // it should produce once the word is accepted. Valid stays high on return.
   task automatic issue_op(func_type f, logic [ID_W-1:0] id, logic [TOTAL_W-1:0] rank);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, rank, id};
      req_tuser  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(), apply_op(f, id, rank));
      ops_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // The register may only change while the block is idle; a write also empties the store.
   task automatic write_highest(logic [ID_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_highest = value;
      wipe_shadow();
      settings_used++;
   endtask

   // Extremes of every field and each corner case, with the register at its reset value.
   task automatic test_basic_ops();
      issue_op(FN_QUERY, 10'd0, '0);
      issue_op(FN_FIND_MAX, 10'd0, '0);        // empty store
      issue_op(FN_POP_MAX, 10'd0, '0);
      issue_op(FN_SELECT, 10'd0, '0);          // rank not below an empty total
      issue_op(FN_INSERT, 10'd0, '0);
      issue_op(FN_INSERT, 10'd0, '0);          // counter already full
      issue_op(FN_INSERT, 10'd127, RANK_MAX);
      issue_op(FN_INSERT, 10'd128, '0);        // just past the highest ID
      issue_op(FN_INSERT, ID_MAX, '0);
      issue_op(FN_QUERY, 10'd127, '0);
      issue_op(FN_FIND_MAX, ID_MAX, RANK_MAX);
      issue_op(FN_SELECT, 10'd0, 18'd0);
      issue_op(FN_SELECT, 10'd0, 18'd1);
      issue_op(FN_SELECT, 10'd0, 18'd2);
      issue_op(FN_SELECT, ID_MAX, RANK_MAX);
      issue_op(FN_POP_MAX, 10'd0, '0);
      issue_op(FN_ERASE, 10'd127, '0);         // nothing left to erase
      issue_op(FN_ERASE, 10'd0, '0);
      issue_op(FN_INSERT, 10'd5, '0);
      issue_op(FN_ERASE_ALL, 10'd5, '0);
      issue_op(FN_ERASE_ALL, 10'd5, '0);
      issue_op(FN_QUERY, ID_MAX, RANK_MAX);
      issue_op(FN_INSERT, 10'd64, '0);
      issue_op(FN_CLEAR, ID_MAX, RANK_MAX);
      issue_op(FN_QUERY, 10'd64, '0);
   endtask

   // Smallest register value, then a value far above the entry count.
   task automatic test_highest_id_extremes();
      write_highest('0);
      issue_op(FN_INSERT, 10'd0, '0);
      issue_op(FN_INSERT, 10'd1, '0);
      issue_op(FN_FIND_MAX, 10'd0, '0);
      issue_op(FN_SELECT, 10'd0, 18'd0);
      write_highest(ID_MAX);
      issue_op(FN_INSERT, 10'd127, '0);
      issue_op(FN_INSERT, 10'd128, '0);
      issue_op(FN_ERASE, 10'd128, '0);
      issue_op(FN_FIND_MAX, 10'd0, '0);
   endtask

   function automatic func_type pick_func();
      int roll;
      roll = $urandom_range(0, 99);
      return (roll < 32) ? FN_INSERT :
             (roll < 44) ? FN_ERASE :
             (roll < 51) ? FN_ERASE_ALL :
             (roll < 62) ? FN_QUERY :
             (roll < 72) ? FN_FIND_MAX :
             (roll < 81) ? FN_POP_MAX :
             (roll < 98) ? FN_SELECT : FN_CLEAR;
   endfunction

   // Mostly in-range IDs and reachable ranks so that the store fills and scans have work.
   task automatic test_random_mix(logic [ID_W-1:0] setting, int n_items);
      func_type           f;
      logic [ID_W-1:0]    id;
      logic [TOTAL_W-1:0] rank;
      write_highest(setting);
      for (int k = 0; k < n_items; k++) begin
         f = pick_func();
         if ($urandom_range(0, 4) != 0) id = ID_W'($urandom_range(0, int'(effective_top())));
         else id = ID_W'($urandom_range(0, int'(ID_MAX)));
         if ($urandom_range(0, 9) < 7) rank = TOTAL_W'($urandom_range(0, int'(shadow_total)));
         else rank = TOTAL_W'($urandom_range(0, int'(RANK_MAX)));
         issue_op(f, id, rank);
      end
   endtask

   // Receiver side: random bursts of ready and of stall.
   always @(posedge clock) begin
      if (reset || !gaps_on) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
         ready_hold = $urandom_range(1, 16);
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted result word is compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[38:0]);
         if (pending_results.size() == 0) begin
            $error("result word with no operation outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", int'(want.status), int'(got.status));
            check_field("present", int'(want.present), int'(got.present));
            check_field("count_value", int'(want.count_value), int'(got.count_value));
            check_field("found_id", int'(want.found_id), int'(got.found_id));
            check_field("total", int'(want.total), int'(got.total));
            results_checked++;
         end
      end
   end

   initial begin
      shadow_highest = HIGHEST_RESET;
      wipe_shadow();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_highest_id_extremes();
      test_random_mix(10'd31, RANDOM_PER_SETTING);
      test_random_mix(ID_MAX, RANDOM_PER_SETTING);
      test_random_mix(ID_W'($urandom_range(1, ENTRIES - 2)), RANDOM_PER_SETTING);
      // The last stretch runs at full rate on both sides.
      wait_drained();
      gaps_on <= 1'b0;
      test_random_mix(HIGHEST_RESET, RANDOM_PER_SETTING);

      wait_drained();
      repeat (2 * ENTRIES + 4) @(posedge clock);
      $display("Sent %0d operations over %0d highest_id settings; %0d result words checked.",
               ops_sent, settings_used, results_checked);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
